// File: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define BER_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("band_energy_ratio: assertion failed");

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define BER_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("band_energy_ratio: assertion failed");

`endif

// File: hdl/ber_pkg.sv
// Package: constants, types and codes of the band energy ratio block.
package ber_pkg;

	localparam int WINDOW_SIZE = 2048;
	localparam int MAG_WIDTH   = 24;

	localparam int MAG_PORT_W = 24;
	localparam int RATE_W     = 18;
	localparam int IDX_W      = 11;
	localparam int SUM_W      = 35;
	localparam int RATIO_W    = 16;
	localparam int Q_W        = RATIO_W + 1;
	localparam int STEP_W     = $clog2(Q_W);
	localparam int PROD_W     = IDX_W + RATE_W;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int LANES      = 3;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
	localparam logic [IDX_W-1:0]  INDEX_MAX  = '1;
	localparam logic [SUM_W-1:0]  SUM_MAX    = '1;
	localparam logic [SUM_W-1:0]  MAG_MASK   = SUM_W'((64'd1 << MAG_WIDTH) - 64'd1);

	// Band edges in units of Hz * WINDOW_SIZE
	localparam logic [PROD_W-1:0] EDGE_BASS_LO = PROD_W'(20 * WINDOW_SIZE);
	localparam logic [PROD_W-1:0] EDGE_MID_LO  = PROD_W'(250 * WINDOW_SIZE);
	localparam logic [PROD_W-1:0] EDGE_HIGH_LO = PROD_W'(2000 * WINDOW_SIZE);
	localparam logic [PROD_W-1:0] EDGE_HIGH_HI = PROD_W'(8000 * WINDOW_SIZE);

	// Register index decoded from paddr[PADDR_W-1:2]
	localparam logic [PADDR_W-3:0] REG_SAMPLE_RATE = '0;

	typedef enum logic [1:0] {
		BAND_NONE,
		BAND_BASS,
		BAND_MID,
		BAND_HIGH
	} band_t;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_LOAD,
		ST_SETUP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic setup;
		logic div_step;
		logic div_first;
	} ber_cmd_t;

endpackage

// File: hdl/ber_ctrl.sv
// Controller: frame sequencing state machine and divider step count.
module ber_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last_bin,
	output logic              busy,
	output logic              done,
	output ber_pkg::ber_cmd_t cmd
);
	import ber_pkg::*;

	state_t            state_q;
	state_t            state_nxt;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_SETUP) begin
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_ACCUM: begin
				if (start && last_bin) begin
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD:  state_nxt = ST_SETUP;
			ST_SETUP: state_nxt = ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_W'(Q_W - 1)) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE:  state_nxt = ST_ACCUM;
			default:  state_nxt = ST_ACCUM;
		endcase
	end

	always_comb begin
		busy          = 1'b1;
		done          = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_ACCUM: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_LOAD:  busy = 1'b1;
			ST_SETUP: cmd.setup = 1'b1;
			ST_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (step_q == '0);
			end
			ST_DONE:  done = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

endmodule

// File: hdl/ber_dp.sv
// Datapath: bin classification, band accumulators and three restoring dividers.
module ber_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ber_pkg::ber_cmd_t              cmd,
	input  logic [ber_pkg::MAG_PORT_W-1:0] magnitude,
	input  logic                           last_bin,
	input  logic [ber_pkg::RATE_W-1:0]     rate,
	output logic [ber_pkg::RATIO_W-1:0]    bass_ratio,
	output logic [ber_pkg::RATIO_W-1:0]    mid_ratio,
	output logic [ber_pkg::RATIO_W-1:0]    high_ratio,
	output logic                           silent
);
	import ber_pkg::*;

	logic [IDX_W-1:0]  idx_q;
	logic [PROD_W-1:0] scaled;
	band_t             band;
	logic              valid_s1;
	band_t             band_s1;
	logic [SUM_W-1:0]  mag_s1;

	logic [SUM_W-1:0]  bass_q, mid_q, high_q, total_q;
	logic [SUM_W:0]    bass_add, mid_add, high_add, total_add;
	logic [SUM_W-1:0]  bass_sat, mid_sat, high_sat, total_sat;

	logic [SUM_W-1:0]  whole_q;
	logic              silent_q;
	logic [SUM_W:0]    rem_q  [LANES];
	logic [Q_W-1:0]    quot_q [LANES];
	logic [SUM_W-1:0]  part   [LANES];
	logic [SUM_W:0]    shifted[LANES];
	logic [SUM_W:0]    diff   [LANES];
	logic              ge     [LANES];
	logic [RATIO_W-1:0] ratio [LANES];

	// Classify the bin from its index before the index advances.
	always_comb begin
		scaled = PROD_W'(idx_q) * PROD_W'(rate);
		if (scaled >= EDGE_BASS_LO && scaled < EDGE_MID_LO) begin
			band = BAND_BASS;
		end else if (scaled >= EDGE_MID_LO && scaled < EDGE_HIGH_LO) begin
			band = BAND_MID;
		end else if (scaled >= EDGE_HIGH_LO && scaled < EDGE_HIGH_HI) begin
			band = BAND_HIGH;
		end else begin
			band = BAND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.accept;
			if (cmd.accept) begin
				if (last_bin) begin
					idx_q <= '0;
				end else if (idx_q != INDEX_MAX) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			band_s1 <= band;
			mag_s1  <= SUM_W'(magnitude) & MAG_MASK;
		end
	end

	// Saturating accumulation
	always_comb begin
		bass_add  = {1'b0, bass_q}  + (SUM_W + 1)'(mag_s1);
		mid_add   = {1'b0, mid_q}   + (SUM_W + 1)'(mag_s1);
		high_add  = {1'b0, high_q}  + (SUM_W + 1)'(mag_s1);
		total_add = {1'b0, total_q} + (SUM_W + 1)'(mag_s1);
		bass_sat  = bass_add[SUM_W]  ? SUM_MAX : bass_add[SUM_W-1:0];
		mid_sat   = mid_add[SUM_W]   ? SUM_MAX : mid_add[SUM_W-1:0];
		high_sat  = high_add[SUM_W]  ? SUM_MAX : high_add[SUM_W-1:0];
		total_sat = total_add[SUM_W] ? SUM_MAX : total_add[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bass_q  <= '0;
			mid_q   <= '0;
			high_q  <= '0;
			total_q <= '0;
		end else if (cmd.setup) begin
			bass_q  <= '0;
			mid_q   <= '0;
			high_q  <= '0;
			total_q <= '0;
		end else if (valid_s1) begin
			total_q <= total_sat;
			case (band_s1)
				BAND_BASS: bass_q <= bass_sat;
				BAND_MID:  mid_q  <= mid_sat;
				BAND_HIGH: high_q <= high_sat;
				default:   ;
			endcase
		end
	end

	assign part[0] = bass_q;
	assign part[1] = mid_q;
	assign part[2] = high_q;

	// One quotient bit per lane per step; remainder stays below the divisor.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			shifted[i] = cmd.div_first ? rem_q[i] : {rem_q[i][SUM_W-1:0], 1'b0};
			ge[i]      = shifted[i] >= {1'b0, whole_q};
			diff[i]    = shifted[i] - {1'b0, whole_q};
			ratio[i]   = silent_q ? '0 :
				(quot_q[i][Q_W-1] ? '1 : quot_q[i][RATIO_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			whole_q  <= total_q;
			silent_q <= (total_q == '0);
			for (int i = 0; i < LANES; i++) begin
				rem_q[i]  <= {1'b0, part[i]};
				quot_q[i] <= '0;
			end
		end else if (cmd.div_step) begin
			for (int i = 0; i < LANES; i++) begin
				rem_q[i]  <= ge[i] ? diff[i] : shifted[i];
				quot_q[i] <= {quot_q[i][Q_W-2:0], ge[i]};
			end
		end
	end

	assign bass_ratio = ratio[0];
	assign mid_ratio  = ratio[1];
	assign high_ratio = ratio[2];
	assign silent     = silent_q;

endmodule

// File: hdl/band_energy_ratio.sv
// Top level: band energy ratio block with APB configuration port.
//
// Streams one frame of FFT magnitude bins, one transaction per bin, and
// reports the bass (20-250 Hz), mid (250-2000 Hz) and high (2000-8000 Hz)
// share of the frame's total magnitude, unsigned Q0.16 (1.0 clips to 65535).
// A bin is accepted at each rising edge with start high and busy low, so
// bins of a frame enter at one per clock. The bin flagged last_bin closes
// the frame: busy then rises through the final add (ST_LOAD), the divider load
// (ST_SETUP), the shared-step restoring dividers that make one quotient bit
// per cycle for all three bands (ST_DIV) and the result (ST_DONE).
// The result appears with done high for exactly one cycle, the last of the
// busy period; the receiver cannot stall, so capture it then. A frame whose
// total is zero reports zero ratios with silent high. Bin index saturates
// at 2047 and the sums at 2^35-1. sample_rate_hz sits at byte address 0
// (reset 44100); write it only while no frame is in progress.
module band_energy_ratio (
	input  logic                           clk,
	input  logic                           arst_n,
	// bin transaction
	input  logic                           start,
	output logic                           busy,
	input  logic [ber_pkg::MAG_PORT_W-1:0] magnitude,
	input  logic                           last_bin,
	// result transaction
	output logic                           done,
	output logic [ber_pkg::RATIO_W-1:0]    bass_ratio,
	output logic [ber_pkg::RATIO_W-1:0]    mid_ratio,
	output logic [ber_pkg::RATIO_W-1:0]    high_ratio,
	output logic                           silent,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ber_pkg::PADDR_W-1:0]    paddr,
	input  logic [ber_pkg::PDATA_W-1:0]    pwdata,
	output logic [ber_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);
	import ber_pkg::*;

	ber_cmd_t          cmd;
	logic [RATE_W-1:0] rate_q;
	logic              reg_hit;

	// Word decode; byte offset bits are ignored.
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_SAMPLE_RATE);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? PDATA_W'(rate_q) : '0;

	// Update the sample rate on the access phase of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			rate_q <= pwdata[RATE_W-1:0];
		end
	end

	// Sequence the frame: accumulate, drain, divide, present.
	ber_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_bin (last_bin),
		.busy     (busy),
		.done     (done),
		.cmd      (cmd)
	);

	// Classify, accumulate and divide.
	ber_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.magnitude  (magnitude),
		.last_bin   (last_bin),
		.rate       (rate_q),
		.bass_ratio (bass_ratio),
		.mid_ratio  (mid_ratio),
		.high_ratio (high_ratio),
		.silent     (silent)
	);

endmodule

// File: hdl/ber_checker.sv
// Port-level checker for band_energy_ratio, attached by bind.
`include "assert_macros.svh"

module ber_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           last_bin,
	input logic                           done,
	input logic [ber_pkg::RATIO_W-1:0]    bass_ratio,
	input logic [ber_pkg::RATIO_W-1:0]    mid_ratio,
	input logic [ber_pkg::RATIO_W-1:0]    high_ratio,
	input logic                           silent
);

	// A result only comes out while no bin can be taken.
	`BER_ASSERT_IMP(a_done_while_busy, done, busy)

	// The result strobe lasts one cycle.
	`BER_ASSERT_NEXT(a_done_single, done, !done)

	// Closing a frame blocks the next bin.
	`BER_ASSERT_NEXT(a_last_sets_busy, start && !busy && last_bin, busy)

	// A silent frame reports zero shares.
	`BER_ASSERT_IMP(a_silent_zero, done && silent, !(|{bass_ratio, mid_ratio, high_ratio}))

endmodule

bind band_energy_ratio ber_checker u_ber_checker (.*);
